// ----- rtl/calendar_date_counter_macros.svh -----
// assertion macros shared by the calendar date counter rtl
`ifndef CALENDAR_DATE_COUNTER_MACROS_SVH
`define CALENDAR_DATE_COUNTER_MACROS_SVH
`ifndef NO_ASSERTIONS
// property that must hold at every clock edge out of reset
`define CDC_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("calendar_date_counter: check failed");
// consequent must hold in the cycle after the antecedent
`define CDC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("calendar_date_counter: check failed");
`else
`define CDC_ASSERT(label, clk, rst_n, prop)
`define CDC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ----- rtl/cdc_pkg.sv -----
// shared types, codes and calendar functions of the calendar date counter
`default_nettype none
package cdc_pkg;

	localparam int DAY_W   = 5;
	localparam int MONTH_W = 4;
	localparam int YEAR_W  = 14;
	localparam int WDAY_W  = 3;
	localparam int WSUM_W  = 15;

	// mode codes
	localparam logic [1:0] MODE_LOAD = 2'd0;
	localparam logic [1:0] MODE_NEXT = 2'd1;
	localparam logic [1:0] MODE_PREV = 2'd2;

	// status codes
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD_DATE = 2'd1;
	localparam logic [1:0] ST_BAD_YEAR = 2'd2;

	// register indexes
	localparam logic REG_MIN_YEAR = 1'b0;
	localparam logic REG_MAX_YEAR = 1'b1;

	localparam logic [YEAR_W-1:0] YEAR_LIMIT    = 14'd16383;
	localparam logic [YEAR_W-1:0] MIN_YEAR_RST  = 14'd1902;
	localparam logic [YEAR_W-1:0] MAX_YEAR_RST  = 14'd2037;
	localparam logic [YEAR_W-1:0] YEAR_RST      = 14'd2000;
	localparam logic [WDAY_W-1:0] WDAY_SATURDAY = 3'd6;

	typedef struct packed {
		logic [1:0]         mode;
		logic [DAY_W-1:0]   day;
		logic [MONTH_W-1:0] month;
		logic [YEAR_W-1:0]  year;
		logic               date_ok;
		logic [WSUM_W-1:0]  wsum;
	} load_item_t;

	typedef struct packed {
		logic [DAY_W-1:0]   day;
		logic [MONTH_W-1:0] month;
		logic [YEAR_W-1:0]  year;
		logic [WDAY_W-1:0]  weekday;
		logic [1:0]         status;
	} result_t;

	// divisibility by 25 through the odd inverse: x*inv mod 2^n stays small
	function automatic logic is_leap(input logic [YEAR_W-1:0] y);
		logic [23:0] p100;
		logic [19:0] p400;
		logic        div100;
		logic        div400;
		p100   = 24'(y[13:2]) * 24'd3113;
		p400   = 20'(y[13:4]) * 20'd41;
		div100 = (p100[11:0] <= 12'd163);
		div400 = (y[3:2] == 2'd0) && (p400[9:0] <= 10'd40);
		return (y[1:0] == 2'd0) && (!div100 || div400);
	endfunction

	function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] m,
			input logic leap);
		logic [DAY_W-1:0] d;
		case (m) inside
			4'd2:                     d = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11:  d = 5'd30;
			default:                  d = 5'd31;
		endcase
		return d;
	endfunction

	function automatic logic [2:0] month_offset(input logic [MONTH_W-1:0] m);
		logic [2:0] o;
		case (m)
			4'd2:    o = 3'd3;
			4'd3:    o = 3'd2;
			4'd4:    o = 3'd5;
			4'd6:    o = 3'd3;
			4'd7:    o = 3'd5;
			4'd8:    o = 3'd1;
			4'd9:    o = 3'd4;
			4'd10:   o = 3'd6;
			4'd11:   o = 3'd2;
			4'd12:   o = 3'd4;
			default: o = 3'd0;
		endcase
		return o;
	endfunction

	// x/25 by reciprocal, exact for x below 4200
	function automatic logic [7:0] div25(input logic [12:0] x);
		logic [23:0] p;
		p = 24'(x) * 24'd1311;
		return p[22:15];
	endfunction

	// s mod 7 by reciprocal, exact for s below 32768
	function automatic logic [WDAY_W-1:0] mod7(input logic [WSUM_W-1:0] s);
		logic [31:0]       p;
		logic [WSUM_W-1:0] q7;
		p  = 32'(s) * 32'd18725;
		q7 = 15'(p[29:17]) * 15'd7;
		return 3'(s - q7);
	endfunction

endpackage
`default_nettype wire

// ----- rtl/cdc_load_prep.sv -----
// validates a load date and forms its weekday sum ahead of the input register
`default_nettype none
module cdc_load_prep (
	input  wire logic [1:0]                  mode,
	input  wire logic [cdc_pkg::DAY_W-1:0]   load_day,
	input  wire logic [cdc_pkg::MONTH_W-1:0] load_month,
	input  wire logic [cdc_pkg::YEAR_W-1:0]  load_year,
	output cdc_pkg::load_item_t              item
);
	import cdc_pkg::*;

	logic [WSUM_W-1:0] yy;
	logic [7:0]        q100;
	logic [7:0]        q400;
	logic              month_ok;

	// january and february count with the year before
	assign yy = 15'(load_year) + 15'd400 - ((load_month < 4'd3) ? 15'd1 : 15'd0);
	assign q100 = div25(yy[14:2]);
	assign q400 = div25({2'b00, yy[14:4]});
	assign month_ok = (load_month >= 4'd1) && (load_month <= 4'd12);

	always_comb begin
		item.mode    = mode;
		item.day     = load_day;
		item.month   = load_month;
		item.year    = load_year;
		item.date_ok = month_ok && (load_day != 5'd0)
			&& (load_day <= days_in(load_month, is_leap(load_year)));
		item.wsum    = yy + 15'(yy[14:2]) - 15'(q100) + 15'(q400)
			+ 15'(month_offset(load_month)) + 15'(load_day);
	end

endmodule
`default_nettype wire

// ----- rtl/cdc_date_core.sv -----
// stored date and weekday with load, next-day and previous-day update
`default_nettype none
`include "calendar_date_counter_macros.svh"
module cdc_date_core (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       adv,
	input  wire cdc_pkg::load_item_t        item,
	input  wire logic [cdc_pkg::YEAR_W-1:0] min_year,
	input  wire logic [cdc_pkg::YEAR_W-1:0] max_year,
	output cdc_pkg::result_t                res
);
	import cdc_pkg::*;

	logic [DAY_W-1:0]   day_q;
	logic [MONTH_W-1:0] month_q;
	logic [YEAR_W-1:0]  year_q;
	logic [WDAY_W-1:0]  weekday_q;

	logic               leap_cur;
	logic [DAY_W-1:0]   dim_cur;
	logic [DAY_W-1:0]   dim_prev;
	logic [DAY_W-1:0]   nd;
	logic [MONTH_W-1:0] nm;
	logic [YEAR_W-1:0]  ny;
	logic               edge_hit;

	function automatic logic in_win(input logic [YEAR_W-1:0] y,
			input logic [YEAR_W-1:0] lo, input logic [YEAR_W-1:0] hi);
		return (y >= lo) && (y <= hi);
	endfunction

	// leap only matters inside the stored year, a year change lands on dec or jan
	assign leap_cur = is_leap(year_q);
	assign dim_cur  = days_in(month_q, leap_cur);
	assign dim_prev = days_in(month_q - 4'd1, leap_cur);

	always_comb begin
		res.day     = day_q;
		res.month   = month_q;
		res.year    = year_q;
		res.weekday = weekday_q;
		res.status  = ST_OK;
		nd          = day_q;
		nm          = month_q;
		ny          = year_q;
		edge_hit    = 1'b0;
		case (item.mode)
			MODE_LOAD: begin
				if (!item.date_ok) begin
					res.status = ST_BAD_DATE;
				end else if (!in_win(item.year, min_year, max_year)) begin
					res.status = ST_BAD_YEAR;
				end else begin
					res.day     = item.day;
					res.month   = item.month;
					res.year    = item.year;
					res.weekday = mod7(item.wsum);
				end
			end
			MODE_NEXT: begin
				if (day_q < dim_cur) begin
					nd = day_q + 5'd1;
				end else if (month_q < 4'd12) begin
					nd = 5'd1;
					nm = month_q + 4'd1;
				end else begin
					nd = 5'd1;
					nm = 4'd1;
					edge_hit = (year_q == YEAR_LIMIT);
					ny = year_q + 14'd1;
				end
				if (edge_hit || !in_win(ny, min_year, max_year)) begin
					res.status = ST_BAD_YEAR;
				end else begin
					res.day     = nd;
					res.month   = nm;
					res.year    = ny;
					res.weekday = (weekday_q == 3'd6) ? 3'd0 : weekday_q + 3'd1;
				end
			end
			MODE_PREV: begin
				if (day_q > 5'd1) begin
					nd = day_q - 5'd1;
				end else if (month_q > 4'd1) begin
					nm = month_q - 4'd1;
					nd = dim_prev;
				end else begin
					nd = 5'd31;
					nm = 4'd12;
					edge_hit = (year_q == 14'd0);
					ny = year_q - 14'd1;
				end
				if (edge_hit || !in_win(ny, min_year, max_year)) begin
					res.status = ST_BAD_YEAR;
				end else begin
					res.day     = nd;
					res.month   = nm;
					res.year    = ny;
					res.weekday = (weekday_q == 3'd0) ? 3'd6 : weekday_q - 3'd1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			day_q     <= 5'd1;
			month_q   <= 4'd1;
			year_q    <= YEAR_RST;
			weekday_q <= WDAY_SATURDAY;
		end else if (adv) begin
			day_q     <= res.day;
			month_q   <= res.month;
			year_q    <= res.year;
			weekday_q <= res.weekday;
		end
	end

	`CDC_ASSERT_NEXT(a_fail_holds, clk, arst_n, adv && (res.status != ST_OK), $stable(day_q) && $stable(month_q) && $stable(year_q) && $stable(weekday_q))
	`CDC_ASSERT(a_date_range, clk, arst_n, (month_q >= 4'd1) && (month_q <= 4'd12) && (day_q >= 5'd1) && (day_q <= dim_cur))
	`CDC_ASSERT_NEXT(a_next_weekday, clk, arst_n, adv && (item.mode == MODE_NEXT) && (res.status == ST_OK), weekday_q == (($past(weekday_q) == 3'd6) ? 3'd0 : $past(weekday_q) + 3'd1))

endmodule
`default_nettype wire

// ----- rtl/calendar_date_counter.sv -----
// top level of the calendar date counter: stream ports, registers, apb port
`default_nettype none
`include "calendar_date_counter_macros.svh"
// Gregorian date counter. Each input word either loads a date (checked
// against month lengths, leap years and the min_year/max_year window) or
// steps the stored date one day forward or back with month and year
// rollover; every input word returns exactly one output word with the
// stored date, its weekday (0 Sunday) and a status (0 ok, 1 bad day or
// month, 2 year outside the window). A failing word leaves the stored date
// alone; mode 3 returns the stored date with status ok. The block takes one
// word per clock unless the output stalls: the load check and weekday sum
// are formed in front of the input register, the date update and weekday
// finish run between the input register and the output register, so a
// result is registered as its word leaves the input register. The rate is
// set by the stored-date update, which each word needs from the word before
// it. The output register parts the two sides, so a new word is taken while
// a finished result waits. After reset the date is 1 January 2000, a
// Saturday, and the window is 1902 to 2037; no warm-up is needed. The
// window registers sit at byte addresses 0 (min_year) and 4 (max_year),
// are 14 bits wide, and may be written only while no word is in flight.
module calendar_date_counter (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input stream
	input  wire logic        s_tvalid,
	output      logic        s_tready,
	input  wire logic [23:0] s_tdata,   // load_day[4:0], load_month[8:5], load_year[22:9], zero
	input  wire logic [1:0]  s_tuser,   // mode[1:0]
	// output stream
	output      logic        m_tvalid,
	input  wire logic        m_tready,
	output      logic [31:0] m_tdata,   // cur_day[4:0], cur_month[8:5], cur_year[22:9],
	                                    // weekday[25:23], zero
	output      logic [1:0]  m_tuser,   // status[1:0]
	// configuration port
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output      logic [31:0] prdata,
	output      logic        pready
);
	import cdc_pkg::*;

	// window registers
	logic [YEAR_W-1:0] min_year_q;
	logic [YEAR_W-1:0] max_year_q;
	logic              cfg_wr;

	// input register and output register
	load_item_t        item_in;
	load_item_t        item_s1;
	logic              valid_s1;
	result_t           res;
	result_t           res_s2;
	logic              valid_s2;
	logic              adv;
	logic              in_acc;

	// apb: always ready, word address picks the register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_year_q <= MIN_YEAR_RST;
			max_year_q <= MAX_YEAR_RST;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				REG_MIN_YEAR: min_year_q <= pwdata[13:0];
				REG_MAX_YEAR: max_year_q <= pwdata[13:0];
				default:      min_year_q <= min_year_q;
			endcase
		end
	end

	assign prdata = (paddr[2] == REG_MAX_YEAR) ? {18'd0, max_year_q} : {18'd0, min_year_q};

	// load check and weekday sum on the incoming word
	cdc_load_prep u_prep (
		.mode       (s_tuser),
		.load_day   (s_tdata[4:0]),
		.load_month (s_tdata[8:5]),
		.load_year  (s_tdata[22:9]),
		.item       (item_in)
	);

	// a word moves into the output register whenever that register is free or being read
	assign adv      = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign in_acc   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_s1 <= item_in;
		end
	end

	// stored date, updated as the word leaves the input register
	cdc_date_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.item     (item_s1),
		.min_year (min_year_q),
		.max_year (max_year_q),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {6'd0, res_s2.weekday, res_s2.year, res_s2.month, res_s2.day};
	assign m_tuser  = res_s2.status;

	// a full input register behind a stalled output must hold off new words
	`CDC_ASSERT(a_stall_blocks, clk, arst_n, (valid_s1 && valid_s2 && !m_tready) |-> !s_tready)
	// a taken word is always held somewhere on the next cycle
	`CDC_ASSERT_NEXT(a_word_kept, clk, arst_n, in_acc, valid_s1)
	// the output register fills only from a word in the input register
	`CDC_ASSERT_NEXT(a_out_source, clk, arst_n, !valid_s1 && (!valid_s2 || m_tready), !valid_s2)

endmodule
`default_nettype wire

// ----- bench/testbench.sv -----
// self-checking testbench for the calendar date counter
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import cdc_pkg::*;

	// mode 3 is not decoded by the block and must leave the date alone
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	// one input word as the sender sees it
	typedef struct packed {
		logic [1:0]         mode;
		logic [DAY_W-1:0]   day;
		logic [MONTH_W-1:0] month;
		logic [YEAR_W-1:0]  year;
	} date_cmd_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata = '0;   // load_day[4:0], load_month[8:5], load_year[22:9], zero
	logic [1:0]  s_tuser = '0;   // mode[1:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;        // cur_day[4:0], cur_month[8:5], cur_year[22:9], weekday[25:23]
	logic [1:0]  m_tuser;        // status[1:0]
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	calendar_date_counter dut (
		.clk, .arst_n,
		.s_tvalid, .s_tready, .s_tdata, .s_tuser,
		.m_tvalid, .m_tready, .m_tdata, .m_tuser,
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
	);

	// 20 ns clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// words waiting for the driver, and dates the block owes us
	date_cmd_t pending_words[$];
	result_t   expected_dates[$];
	int        words_queued = 0;
	int        words_taken = 0;
	int        mismatch_cnt = 0;
	logic      in_fire = 1'b0;

	// idling knobs, set per phase by the sequencer
	int        src_idle_pct = 0;
	int        snk_stall_pct = 0;
	logic      hold_arm = 1'b0;
	logic      hold_done = 1'b0;
	int        hold_left = 0;

	// shadow of the block: stored date, weekday and year window
	int        cal_day = 1;
	int        cal_month = 1;
	int        cal_year = int'(YEAR_RST);
	int        cal_wday = int'(WDAY_SATURDAY);
	int        win_lo = int'(MIN_YEAR_RST);
	int        win_hi = int'(MAX_YEAR_RST);

	// gregorian rule: every 4th year, but centuries only every 400th
	function automatic bit leap_year(input int y);
		return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
	endfunction

	function automatic int month_days(input int m, input int y);
		case (m)
			2:             return leap_year(y) ? 29 : 28;
			4, 6, 9, 11:   return 30;
			default:       return 31;
		endcase
	endfunction

	// sakamoto's method, year moved up 400 so january and february stay positive
	function automatic int weekday_of_date(input int d, input int m, input int y);
		int shift[12] = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};
		int yy;
		yy = y + 400 - ((m < 3) ? 1 : 0);
		return (yy + yy / 4 - yy / 100 + yy / 400 + shift[m - 1] + d) % 7;
	endfunction

	function automatic bit year_allowed(input int y);
		return (y >= win_lo) && (y <= win_hi);
	endfunction

	// apply one word to the shadow date and give back the result it owes
	task automatic advance_calendar(input date_cmd_t c, output result_t r);
		int       d;
		int       m;
		int       y;
		bit       off_range;
		logic [1:0] st;
		d = cal_day;
		m = cal_month;
		y = cal_year;
		off_range = 1'b0;
		st = ST_OK;
		case (c.mode)
			MODE_LOAD: begin
				// day and month are checked before the window
				if (c.month == 0 || c.month > 12 || c.day == 0
						|| c.day > month_days(c.month, c.year)) begin
					st = ST_BAD_DATE;
				end else if (!year_allowed(c.year)) begin
					st = ST_BAD_YEAR;
				end else begin
					cal_day = c.day;
					cal_month = c.month;
					cal_year = c.year;
					cal_wday = weekday_of_date(c.day, c.month, c.year);
				end
			end
			MODE_NEXT: begin
				if (d < month_days(m, y)) begin
					d++;
				end else begin
					d = 1;
					if (m < 12) begin
						m++;
					end else begin
						m = 1;
						// no year after the largest one the field holds
						if (y >= YEAR_LIMIT)
							off_range = 1'b1;
						else
							y++;
					end
				end
				if (off_range || !year_allowed(y)) begin
					st = ST_BAD_YEAR;
				end else begin
					cal_day = d;
					cal_month = m;
					cal_year = y;
					cal_wday = (cal_wday + 1) % 7;
				end
			end
			MODE_PREV: begin
				if (d > 1) begin
					d--;
				end else if (m > 1) begin
					m--;
					d = month_days(m, y);
				end else if (y == 0) begin
					// nothing before 1 january of year 0
					off_range = 1'b1;
				end else begin
					y--;
					m = 12;
					d = 31;
				end
				if (off_range || !year_allowed(y)) begin
					st = ST_BAD_YEAR;
				end else begin
					cal_day = d;
					cal_month = m;
					cal_year = y;
					cal_wday = (cal_wday + 6) % 7;
				end
			end
			default: ;
		endcase
		r.day = DAY_W'(cal_day);
		r.month = MONTH_W'(cal_month);
		r.year = YEAR_W'(cal_year);
		r.weekday = WDAY_W'(cal_wday);
		r.status = st;
	endtask

	task automatic queue_word(input logic [1:0] mode, input int d, input int m, input int y);
		date_cmd_t w;
		w.mode = mode;
		w.day = DAY_W'(d);
		w.month = MONTH_W'(m);
		w.year = YEAR_W'(y);
		pending_words.push_back(w);
		words_queued++;
	endtask

	// year for a load: mostly inside the window, some hugging its bounds
	function automatic int pick_year();
		int r;
		int y;
		r = $urandom_range(99);
		if (win_lo <= win_hi && r < 65) begin
			y = $urandom_range(win_hi, win_lo);
		end else if (r < 85) begin
			y = (r % 2 == 0) ? win_lo : win_hi;
			y = y + $urandom_range(4) - 2;
		end else begin
			y = $urandom_range(16383);
		end
		if (y < 0)
			y = 0;
		if (y > 16383)
			y = 16383;
		return y;
	endfunction

	// random words: valid loads near month ends, bursts of steps, some noise
	task automatic queue_random_words(input int n);
		int cnt;
		int r;
		int d;
		int m;
		int y;
		int run;
		logic [1:0] step;
		cnt = 0;
		while (cnt < n) begin
			r = $urandom_range(99);
			if (r < 35) begin
				case ($urandom_range(5))
					0:       m = 2;
					1:       m = 12;
					2:       m = 1;
					default: m = $urandom_range(12, 1);
				endcase
				y = pick_year();
				d = month_days(m, y);
				case ($urandom_range(3))
					0:       d = d - $urandom_range(1);
					1:       d = 1;
					default: d = $urandom_range(d, 1);
				endcase
				queue_word(MODE_LOAD, d, m, y);
				cnt++;
			end else if (r < 45) begin
				// malformed or arbitrary load
				queue_word(MODE_LOAD, $urandom_range(31), $urandom_range(15),
					$urandom_range(16383));
				cnt++;
			end else if (r < 95) begin
				step = (r < 70) ? MODE_NEXT : MODE_PREV;
				run = $urandom_range(6, 1);
				repeat (run) begin
					queue_word(step, $urandom_range(31), $urandom_range(15),
						$urandom_range(16383));
					cnt++;
				end
			end else begin
				queue_word(MODE_UNUSED, $urandom_range(31), $urandom_range(15),
					$urandom_range(16383));
				cnt++;
			end
		end
	endtask

	// wait until every queued word went in and its date came back
	task automatic wait_drained();
		while (words_taken != words_queued || expected_dates.size() != 0)
			@(negedge clk);
		// then let the two-stage pipeline settle
		repeat (3) @(negedge clk);
	endtask

	// register write with setup and access phases, shadow window updated at the write edge
	task automatic write_window_reg(input logic idx, input int value);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= 32'(value);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (idx == REG_MIN_YEAR)
			win_lo = value & 16'h3FFF;
		else
			win_hi = value & 16'h3FFF;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// one random phase: new window, new idling mix, then the words
	task automatic run_phase(input int lo, input int hi, input int src, input int snk,
			input int n, input bit arm);
		wait_drained();
		write_window_reg(REG_MIN_YEAR, lo);
		write_window_reg(REG_MAX_YEAR, hi);
		src_idle_pct = src;
		snk_stall_pct = snk;
		hold_arm = arm;
		queue_random_words(n);
	endtask

	// driver: one word offered until taken, random gaps between words
	always @(negedge clk) begin
		date_cmd_t w;
		logic      busy;
		busy = s_tvalid && !in_fire;
		if (!busy && arst_n && pending_words.size() > 0
				&& $urandom_range(99) >= src_idle_pct) begin
			w = pending_words.pop_front();
			s_tvalid <= 1'b1;
			s_tdata <= {1'b0, w.year, w.month, w.day};
			s_tuser <= w.mode;
		end else if (!busy) begin
			// idle: junk on the data lines
			s_tvalid <= 1'b0;
			s_tdata <= 24'($urandom);
			s_tuser <= 2'($urandom);
		end
	end

	// receiver: random stalls, plus one long hold-off to back up the block
	always @(negedge clk) begin
		logic rdy;
		rdy = ($urandom_range(99) >= snk_stall_pct);
		if (hold_left > 0) begin
			rdy = 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_arm && !hold_done) begin
			rdy = 1'b0;
			hold_left <= 300;
			hold_done <= 1'b1;
		end
		m_tready <= rdy;
	end

	// monitor: predict on each accepted input word, check each output word
	always @(posedge clk) begin
		date_cmd_t c;
		result_t   want;
		result_t   got;
		in_fire <= arst_n && s_tvalid && s_tready;
		if (arst_n && m_tvalid && m_tready) begin
			got = {m_tdata[4:0], m_tdata[8:5], m_tdata[22:9], m_tdata[25:23], m_tuser};
			if (expected_dates.size() == 0) begin
				mismatch_cnt++;
				if (mismatch_cnt <= 10)
					$display("unexpected word: day %0d month %0d year %0d weekday %0d status %0d",
						got.day, got.month, got.year, got.weekday, got.status);
			end else begin
				want = expected_dates.pop_front();
				if (got.day !== want.day || got.month !== want.month
						|| got.year !== want.year || got.weekday !== want.weekday
						|| got.status !== want.status) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display({"mismatch: expected %0d/%0d/%0d wd %0d st %0d,",
							" got %0d/%0d/%0d wd %0d st %0d"},
							want.day, want.month, want.year, want.weekday, want.status,
							got.day, got.month, got.year, got.weekday, got.status);
				end
			end
		end
		if (arst_n && s_tvalid && s_tready) begin
			c = {s_tuser, s_tdata[4:0], s_tdata[8:5], s_tdata[22:9]};
			advance_calendar(c, want);
			expected_dates.push_back(want);
			words_taken++;
		end
	end

	// sequencer
	initial begin
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset window 1902..2037, date starts at 1 jan 2000
		queue_word(MODE_UNUSED, 31, 15, 16383);
		queue_word(MODE_PREV, 0, 0, 0);       // back across the year boundary
		queue_word(MODE_NEXT, 31, 15, 16383);
		queue_word(MODE_LOAD, 29, 2, 2000);   // century leap year
		queue_word(MODE_NEXT, 0, 0, 0);
		queue_word(MODE_PREV, 0, 0, 0);
		queue_word(MODE_LOAD, 29, 2, 1900);   // century, not leap, bad date wins
		queue_word(MODE_LOAD, 31, 4, 2001);   // thirty-day month
		queue_word(MODE_LOAD, 0, 5, 2001);
		queue_word(MODE_LOAD, 1, 0, 2001);
		queue_word(MODE_LOAD, 1, 13, 2001);
		queue_word(MODE_LOAD, 31, 15, 16383);
		queue_word(MODE_LOAD, 15, 6, 1901);   // below the window
		queue_word(MODE_LOAD, 15, 6, 2038);   // above the window
		queue_word(MODE_LOAD, 31, 12, 2037);
		queue_word(MODE_NEXT, 0, 0, 0);       // would leave the window
		queue_word(MODE_LOAD, 1, 1, 1902);
		queue_word(MODE_PREV, 0, 0, 0);       // would leave the window
		queue_word(MODE_LOAD, 28, 2, 2023);
		queue_word(MODE_NEXT, 0, 0, 0);

		// full year range: step off either end of the field
		wait_drained();
		write_window_reg(REG_MIN_YEAR, 0);
		write_window_reg(REG_MAX_YEAR, 16383);
		queue_word(MODE_LOAD, 1, 1, 0);
		queue_word(MODE_PREV, 0, 0, 0);
		queue_word(MODE_LOAD, 29, 2, 0);      // year 0 counts as leap
		queue_word(MODE_LOAD, 31, 12, 16383);
		queue_word(MODE_NEXT, 0, 0, 0);
		queue_word(MODE_LOAD, 0, 0, 0);

		// random phases: window, sender idle %, receiver stall %, words, hold-off
		run_phase(0, 16383, 0, 0, 300, 1'b1);
		run_phase(1902, 2037, 51, 0, 250, 1'b0);
		run_phase(2000, 2000, 0, 51, 200, 1'b0);
		run_phase(3000, 2999, 21, 21, 120, 1'b0);   // empty window
		run_phase(5000, 5010, 0, 0, 150, 1'b0);     // stored date left outside
		run_phase(16380, 16383, 51, 0, 180, 1'b0);
		run_phase(0, 3, 0, 51, 180, 1'b0);
		run_phase(10, 9990, 21, 21, 150, 1'b0);

		wait_drained();
		repeat (5) @(negedge clk);
		if (mismatch_cnt == 0 && expected_dates.size() == 0)
			$display("** calendar_date_counter: PASSED **");
		else
			$display("** calendar_date_counter: FAILED **");
		$finish;
	end

	// watchdog
	initial begin
		#2_000_000;
		$display("** calendar_date_counter: FAILED **");
		$finish;
	end

endmodule
